// File: rtl/huffman_tree_walk_decoder_unit_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef HUFFMAN_TREE_WALK_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define HTWD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htwd assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define HTWD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htwd assertion failed");
`else
`define HTWD_ASSERT_IMP(label, ante, cons)
`define HTWD_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/htwd_pkg.sv
// Types and constants of the Huffman tree-walk decoder.
package htwd_pkg;

  localparam int NODE_COUNT_DEF = 512;
  localparam int NODE_W         = 9;
  localparam int SYM_W          = 8;
  localparam int COUNT_W        = 31;
  localparam int BYTE_W         = 8;
  localparam int BCNT_W         = 4;

  // Request codes.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_DATA  = 2'd2;

  // Result status codes.
  localparam logic STAT_SYMBOL = 1'b0;
  localparam logic STAT_ABSENT = 1'b1;

  // One node table entry as it is stored in memory.
  typedef struct packed {
    logic              leaf;
    logic              rpres;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [SYM_W-1:0]  chr;
  } node_ent_t;

  localparam int ENT_W = $bits(node_ent_t);

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             status;
    logic             done;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOTWT,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Where the entry of the current node comes from in a walk cycle.
  typedef enum logic [1:0] {
    SRC_ROOT,
    SRC_ARRIVE,
    SRC_PLAIN
  } src_mode_t;

endpackage

// File: rtl/huffman_tree_walk_decoder_unit.sv
// Top level of the Huffman tree-walk decoder.
// The decoder walks a code tree held in a node table, one bit of each data
// beat per cycle unless the result path stalls, most significant bit first.
// Load beats write one node and start beats set the root and the symbol
// count; these, and a data beat that arrives while the symbol count is zero,
// leave the decoder idle, so the next beat can follow straight after. Any
// other data beat holds the input from its acceptance to the next accepted
// beat while the decoder works through its steps in order: acceptance, a
// step per bit (an absent child is reported within the step of its bit), a
// step back to the root after each decoded symbol, a check of the node
// reached by the last bit, and the handover of the last result. A beat that
// ends the symbol count skips the bits after its last symbol and the check.
// The first data beat after a start or a load first fetches the root entry.
// The single read port of the node table paces the walk, since every bit
// needs the entry of the node chosen by the bit before. The next beat is
// taken once the current data beat is finished; its last result may still
// wait in the output register.
`include "huffman_tree_walk_decoder_unit_macros.svh"

module huffman_tree_walk_decoder_unit
  import htwd_pkg::*;
  #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
  )
  (
    input  logic               clk,
    input  logic               rst,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         req_type,
    input  logic [NODE_W-1:0]  node_index,
    input  logic [NODE_W-1:0]  left_child,
    input  logic [NODE_W-1:0]  right_child,
    input  logic               right_present,
    input  logic               is_leaf,
    input  logic [SYM_W-1:0]   leaf_symbol,
    input  logic [NODE_W-1:0]  root_index,
    input  logic [COUNT_W-1:0] symbol_count,
    input  logic [BYTE_W-1:0]  data_byte,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [SYM_W-1:0]   symbol,
    output logic               status,
    output logic               stream_done,
    output logic               last
  );

  localparam int AW    = $clog2(NODE_COUNT);
  localparam int CMP_W = ((AW > NODE_W) ? AW : NODE_W) + 1;

  function automatic logic in_range(logic [NODE_W-1:0] x);
    return CMP_W'(x) < CMP_W'(NODE_COUNT);
  endfunction

  function automatic logic [AW-1:0] to_addr(logic [NODE_W-1:0] x);
    logic [CMP_W-1:0] w;
    w = CMP_W'(x);
    return w[AW-1:0];
  endfunction

  state_t             state, state_next;
  src_mode_t          mode, mode_next;
  logic [NODE_W-1:0]  cur, cur_next;
  logic               at_root, at_root_next;
  logic [NODE_W-1:0]  root;
  logic               root_ok;
  node_ent_t          root_ent;
  logic               root_ent_ok, root_ent_ok_next;
  logic [COUNT_W-1:0] remaining, remaining_next;
  logic [BYTE_W-1:0]  bits, bits_next;
  logic [BCNT_W-1:0]  bcnt, bcnt_next;
  result_t            pend, pend_next;
  logic               pend_v, pend_v_next;

  logic               item_acc;
  logic               can_push;
  logic               push;
  logic               push_last;
  logic               walk_adv;
  logic               walk_end;

  logic               we;
  logic               rd_en;
  logic [AW-1:0]      raddr;
  node_ent_t          wr_ent;
  logic [ENT_W-1:0]   rdata_raw;
  node_ent_t          rdata;

  node_ent_t          src;
  logic               src_ok;
  logic               step_bit;
  logic [NODE_W-1:0]  nxt;
  logic               nxt_ok;
  logic               arr_leaf;
  logic               last_sym;

  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign can_push   = !result_valid || !result_stall;

  assign wr_ent = '{leaf: is_leaf, rpres: right_present, left: left_child,
                    right: right_child, chr: leaf_symbol};
  assign rdata  = node_ent_t'(rdata_raw);

  htwd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (we),
    .waddr (to_addr(node_index)),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // One tree step from the entry of the current node.
  assign arr_leaf = (mode == SRC_ARRIVE) && rdata.leaf;
  assign src      = (mode == SRC_ROOT) ? root_ent : rdata;
  assign src_ok   = (mode == SRC_ROOT) ? root_ok : 1'b1;
  assign step_bit = bits[BYTE_W-1];
  assign nxt      = step_bit ? src.right : src.left;
  assign nxt_ok   = src_ok && !src.leaf && (!step_bit || src.rpres) && in_range(nxt);
  assign last_sym = (remaining == COUNT_W'(1));

  // A new result may move into the pending slot only if the older one can
  // go to the output register at the same edge.
  assign walk_adv = !(pend_v && !can_push && (arr_leaf || (bcnt != BCNT_W'(BYTE_W) && !nxt_ok)));
  assign walk_end = (arr_leaf && last_sym) || (!arr_leaf && bcnt == BCNT_W'(BYTE_W));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_acc && req_type == REQ_DATA && remaining != '0) begin
          state_next = root_ent_ok ? ST_WALK : ST_ROOTWT;
        end
      end
      ST_ROOTWT: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (walk_adv && walk_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v || can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mode_next        = mode;
    cur_next         = cur;
    at_root_next     = at_root;
    root_ent_ok_next = root_ent_ok;
    remaining_next   = remaining;
    bits_next        = bits;
    bcnt_next        = bcnt;
    pend_next        = pend;
    pend_v_next      = pend_v;
    push             = 1'b0;
    push_last        = 1'b0;
    we               = 1'b0;
    rd_en            = 1'b0;
    raddr            = to_addr(cur);
    unique case (state)
      ST_IDLE: begin
        if (item_acc) begin
          unique case (req_type)
            REQ_LOAD: begin
              we               = in_range(node_index);
              root_ent_ok_next = 1'b0;
            end
            REQ_START: begin
              cur_next         = root_index;
              at_root_next     = 1'b1;
              root_ent_ok_next = 1'b0;
              remaining_next   = symbol_count;
            end
            REQ_DATA: begin
              bits_next = data_byte;
              bcnt_next = '0;
              if (!root_ent_ok) begin
                rd_en = 1'b1;
                raddr = to_addr(root);
              end else if (!at_root) begin
                rd_en     = 1'b1;
                mode_next = SRC_PLAIN;
              end else begin
                mode_next = SRC_ROOT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROOTWT: begin
        root_ent_ok_next = 1'b1;
        if (at_root) begin
          mode_next = SRC_ROOT;
        end else begin
          rd_en     = 1'b1;
          mode_next = SRC_PLAIN;
        end
      end
      ST_WALK: begin
        if (walk_adv) begin
          if (arr_leaf) begin
            push           = pend_v;
            pend_next      = '{sym: rdata.chr, status: STAT_SYMBOL, done: last_sym};
            pend_v_next    = 1'b1;
            remaining_next = remaining - COUNT_W'(1);
            cur_next       = root;
            at_root_next   = 1'b1;
            mode_next      = SRC_ROOT;
          end else if (bcnt != BCNT_W'(BYTE_W)) begin
            bits_next = {bits[BYTE_W-2:0], 1'b0};
            bcnt_next = bcnt + BCNT_W'(1);
            if (nxt_ok) begin
              rd_en        = 1'b1;
              raddr        = to_addr(nxt);
              cur_next     = nxt;
              at_root_next = 1'b0;
              mode_next    = SRC_ARRIVE;
            end else begin
              push         = pend_v;
              pend_next    = '{sym: '0, status: STAT_ABSENT, done: 1'b0};
              pend_v_next  = 1'b1;
              cur_next     = root;
              at_root_next = 1'b1;
              mode_next    = SRC_ROOT;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v && can_push) begin
          push        = 1'b1;
          push_last   = 1'b1;
          pend_v_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= SRC_ROOT;
      cur          <= '0;
      at_root      <= 1'b1;
      root         <= '0;
      root_ok      <= in_range('0);
      root_ent_ok  <= 1'b0;
      remaining    <= '0;
      bcnt         <= '0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      mode        <= mode_next;
      cur         <= cur_next;
      at_root     <= at_root_next;
      root_ent_ok <= root_ent_ok_next;
      remaining   <= remaining_next;
      bcnt        <= bcnt_next;
      pend_v      <= pend_v_next;
      if (item_acc && req_type == REQ_START) begin
        root    <= root_index;
        root_ok <= in_range(root_index);
      end
      if (push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bits <= bits_next;
    pend <= pend_next;
    if (state == ST_ROOTWT) begin
      root_ent <= rdata;
    end
    if (push) begin
      symbol      <= pend.sym;
      status      <= pend.status;
      stream_done <= pend.done;
      last        <= push_last;
    end
  end

  `HTWD_ASSERT_IMP(a_err_clean, result_valid && status == STAT_ABSENT, symbol == '0 && !stream_done)
  `HTWD_ASSERT_IMP(a_done_last, result_valid && stream_done, last)
  `HTWD_ASSERT_IMP(a_idle_no_pend, state == ST_IDLE, !pend_v)
  `HTWD_ASSERT_NXT(a_rem_no_grow, !(item_acc && req_type == REQ_START), remaining <= $past(remaining))
  `HTWD_ASSERT_IMP(a_bcnt_range, state == ST_WALK, bcnt <= BCNT_W'(BYTE_W))

endmodule

// File: rtl/htwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module htwd_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
  )
  (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
